// File: rtl/usd_pkg.sv
// Package for the UTF-8 stream decoder: transaction payload types, the
// command passed from front to back, and decoding constants. No dependencies.
`default_nettype none

package usd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned REP_W    = 3;
    localparam int unsigned SEQ_W    = 2;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            last_of_run;
    } t_out_item;

    // rep_cnt replacement results first, then the decoded value if has_val
    typedef struct packed {
        logic [REP_W-1:0] rep_cnt;
        logic             has_val;
        logic [CP_W-1:0]  val;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/usd_front.sv
// Front end: accepts bytes, tracks the open sequence and classifies each byte
// into at most one result command. Depends on usd_pkg.
`default_nettype none

module usd_front import usd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd
);

    logic [SEQ_W-1:0] r_need, n_need;
    logic [SEQ_W-1:0] r_taken, n_taken;
    logic [CP_W-1:0]  r_pv, n_pv;

    logic [BYTE_W-1:0] b;
    logic              is_open;
    logic              is_cont;
    logic [SEQ_W-1:0]  need_dec;
    logic [SEQ_W-1:0]  taken_inc;
    logic [CP_W-1:0]   pv_shift;
    logic [REP_W-1:0]  rep;
    logic              has_val;
    logic [CP_W-1:0]   val;

    assign b         = i_item.data_byte;
    assign is_open   = (r_need != '0);
    assign is_cont   = (b[7:6] == 2'b10);
    assign need_dec  = r_need - SEQ_W'(1);
    assign taken_inc = r_taken + SEQ_W'(1);
    assign pv_shift  = {r_pv[CP_W-7:0], b[5:0]};

    always_comb begin
        n_need  = r_need;
        n_taken = r_taken;
        n_pv    = r_pv;
        rep     = '0;
        has_val = 1'b0;
        val     = '0;
        if (is_open && is_cont) begin
            n_need  = need_dec;
            n_taken = taken_inc;
            n_pv    = pv_shift;
            if (need_dec == '0) begin
                has_val = 1'b1;
                val     = pv_shift;
                n_taken = '0;
                n_pv    = '0;
            end else if (i_item.end_of_text) begin
                rep     = REP_W'(taken_inc) + REP_W'(1);
                n_need  = '0;
                n_taken = '0;
                n_pv    = '0;
            end
        end else begin
            if (is_open) begin
                rep = REP_W'(r_taken) + REP_W'(1);
            end
            n_need  = '0;
            n_taken = '0;
            n_pv    = '0;
            if (b[7] == 1'b0) begin
                has_val = 1'b1;
                val     = CP_W'(b);
            end else if (b[7:5] == 3'b110) begin
                n_need = SEQ_W'(1);
                n_pv   = CP_W'(b[4:0]);
            end else if (b[7:4] == 4'b1110) begin
                n_need = SEQ_W'(2);
                n_pv   = CP_W'(b[3:0]);
            end else if (b[7:3] == 5'b11110) begin
                n_need = SEQ_W'(3);
                n_pv   = CP_W'(b[2:0]);
            end else begin
                rep = rep + REP_W'(1);
            end
            if (i_item.end_of_text && (n_need != '0)) begin
                rep     = rep + REP_W'(1);
                n_need  = '0;
                n_pv    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need  <= '0;
            r_taken <= '0;
            r_pv    <= '0;
        end else if (i_accept) begin
            r_need  <= n_need;
            r_taken <= n_taken;
            r_pv    <= n_pv;
        end
    end

    assign o_cmd_valid   = i_accept && ((rep != '0) || has_val);
    assign o_cmd.rep_cnt = rep;
    assign o_cmd.has_val = has_val;
    assign o_cmd.val     = val;

endmodule

`default_nettype wire

// File: rtl/usd_cmd_fifo.sv
// Command queue between front and back: register array with read and write
// pointers and an occupancy count. Depends on usd_pkg.
`default_nettype none

module usd_cmd_fifo import usd_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_en,
    input  wire t_cmd i_wr_data,
    input  wire logic i_rd_en,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_rd_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr;
    logic             rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr        = i_wr_en && !o_full;
    assign rd        = i_rd_en && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr && !rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd && !wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("command queue over capacity");

endmodule

`default_nettype wire

// File: rtl/usd_back.sv
// Back end: expands each queued command into its results and holds the
// oldest result in the output register. Depends on usd_pkg.
`default_nettype none

module usd_back import usd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_rd,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic [SEQ_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             load;
    logic             em_rep;
    logic [REP_W-1:0] idx_ext;
    t_out_item        em_item;

    assign idx_ext = REP_W'(r_idx);
    assign load    = i_cmd_valid && (!r_out_valid || i_pop);
    assign em_rep  = (idx_ext < i_cmd.rep_cnt);

    always_comb begin
        em_item.replaced = em_rep;
        if (em_rep) begin
            em_item.code_point  = CP_REPLACEMENT;
            em_item.last_of_run = ((idx_ext + REP_W'(1)) == i_cmd.rep_cnt) && !i_cmd.has_val;
        end else begin
            em_item.code_point  = i_cmd.val;
            em_item.last_of_run = 1'b1;
        end
    end

    assign o_cmd_rd = load && em_item.last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= em_item.last_of_run ? '0 : r_idx + SEQ_W'(1);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= em_item;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    a_cmd_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> ((i_cmd.rep_cnt != '0) || i_cmd.has_val))
        else $error("queued command carries no result");

    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && !em_rep) |-> i_cmd.has_val)
        else $error("expansion index ran past command");

    a_value_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.replaced) |-> r_out.last_of_run)
        else $error("decoded value not marked last of run");

endmodule

`default_nettype wire

// File: rtl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder top level: front end, command queue, back end.
// Throughput: one byte per cycle while the queue is not full; results leave one at a time.
// A result passes through the command queue and then the back-end output register.
// Bytes that yield no result never reach the queue. Queue depth QUEUE_DEPTH (2..16).
// Reset: synchronous, active low; closes any open sequence and empties queue and output.
`default_nettype none

module utf8_stream_decoder_core import usd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_in_item,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_out_item
);

    logic accept;
    logic cmd_wr;
    t_cmd cmd_in;
    logic cmd_valid;
    t_cmd cmd_out;
    logic cmd_rd;

    assign accept = push && !full;

    usd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_cmd_valid (cmd_wr),
        .o_cmd       (cmd_in)
    );

    usd_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (cmd_wr),
        .i_wr_data (cmd_in),
        .i_rd_en   (cmd_rd),
        .o_full    (full),
        .o_valid   (cmd_valid),
        .o_rd_data (cmd_out)
    );

    usd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_rd    (cmd_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking bench for utf8_stream_decoder_core: drives bytes through the push/full side,
// predicts every code point, and checks what comes out on the empty/pop side.
// Depends on usd_pkg and utf8_stream_decoder_core.
`default_nettype none

module tb import usd_pkg::*; ;

    localparam int RAND_ITEMS = 96;
    localparam int IDLE_LIMIT = 1000;

    class decode_tracker;
        logic [SEQ_W-1:0] left_cnt;
        logic [SEQ_W-1:0] took_cnt;
        logic [CP_W-1:0]  gathered;
        t_out_item        pending_cps[$];
        int               n_bytes;
        int               n_ends;
        int               n_results;
        int               n_replaced;
        int               n_err;

        function new();
            left_cnt   = '0;
            took_cnt   = '0;
            gathered   = '0;
            n_bytes    = 0;
            n_ends     = 0;
            n_results  = 0;
            n_replaced = 0;
            n_err      = 0;
        endfunction

        function void add_cp(logic [CP_W-1:0] cp, logic rep);
            t_out_item r;
            r.code_point  = cp;
            r.replaced    = rep;
            r.last_of_run = 1'b0;
            pending_cps.push_back(r);
        endfunction

        function void close_seq();
            left_cnt = '0;
            took_cnt = '0;
            gathered = '0;
        endfunction

        function void flush_broken();
            add_cp(CP_REPLACEMENT, 1'b1);
            for (int k = 0; k < took_cnt; k++) add_cp(CP_REPLACEMENT, 1'b1);
            close_seq();
        endfunction

        function void open_byte(logic [BYTE_W-1:0] b);
            casez (b)
                8'b0???????: add_cp({13'd0, b}, 1'b0);
                8'b110?????: begin
                    left_cnt = 2'd1;
                    took_cnt = 2'd0;
                    gathered = {16'd0, b[4:0]};
                end
                8'b1110????: begin
                    left_cnt = 2'd2;
                    took_cnt = 2'd0;
                    gathered = {17'd0, b[3:0]};
                end
                8'b11110???: begin
                    left_cnt = 2'd3;
                    took_cnt = 2'd0;
                    gathered = {18'd0, b[2:0]};
                end
                default: add_cp(CP_REPLACEMENT, 1'b1);
            endcase
        endfunction

        function void take_byte(t_in_item it);
            int        before_cnt;
            t_out_item tail;
            before_cnt = pending_cps.size();
            n_bytes++;
            if (it.end_of_text) n_ends++;
            if (left_cnt != 0 && it.data_byte[7:6] == 2'b10) begin
                gathered = {gathered[CP_W-7:0], it.data_byte[5:0]};
                left_cnt = left_cnt - 2'd1;
                took_cnt = took_cnt + 2'd1;
                if (left_cnt == 0) begin
                    add_cp(gathered, 1'b0);
                    close_seq();
                end
            end else begin
                if (left_cnt != 0) flush_broken();
                open_byte(it.data_byte);
            end
            if (it.end_of_text && left_cnt != 0) flush_broken();
            if (pending_cps.size() > before_cnt) begin
                tail = pending_cps.pop_back();
                tail.last_of_run = 1'b1;
                pending_cps.push_back(tail);
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            n_err++;
        endtask

        task check_code_point(t_out_item got);
            t_out_item want;
            if (pending_cps.size() == 0) begin
                report($sformatf("result with nothing pending, cp=%h", got.code_point));
                return;
            end
            want = pending_cps.pop_front();
            n_results++;
            if (want.replaced) n_replaced++;
            if (got.code_point !== want.code_point)
                report($sformatf("result %0d code_point %h, want %h",
                                 n_results, got.code_point, want.code_point));
            if (got.replaced !== want.replaced)
                report($sformatf("result %0d replaced %b, want %b",
                                 n_results, got.replaced, want.replaced));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("result %0d last_of_run %b, want %b",
                                 n_results, got.last_of_run, want.last_of_run));
        endtask
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  in_item = '0;
    logic      full;
    logic      empty;
    t_out_item out_item;

    decode_tracker sb = new();

    int        burst_left = 0;
    int        idle_cycles = 0;
    int        cyc = 0;
    logic [7:0] seq_bytes[$];
    logic [8:0] directed_items[$] = '{
        {8'h00, 1'b0}, {8'h7F, 1'b0},
        {8'hC2, 1'b0}, {8'hA9, 1'b0},
        {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b0},
        {8'hF4, 1'b0}, {8'h8F, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
        {8'h80, 1'b0}, {8'hFF, 1'b0},
        {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'h41, 1'b0},
        {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b0}, {8'hFF, 1'b0},
        {8'hC3, 1'b0}, {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b1},
        {8'hDF, 1'b1}
    };

    utf8_stream_decoder_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) sb.take_byte(in_item);
        if (i_rst_n && pop && !empty) sb.check_code_point(out_item);
    end

    // rotate receiver behavior through four pop patterns, chosen by cycle counter bits 7:6
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        case (cyc[7:6])
            2'd0: pop <= 1'b1;
            2'd1: pop <= 1'($urandom_range(0, 1));
            2'd2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= cyc[3];
        endcase
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
        push                  <= 1'b1;
        in_item.data_byte     <= b;
        in_item.end_of_text   <= eot;
        do @(posedge i_clk); while (full);
        burst_left--;
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending_cps.size() != 0);
    endtask

    task automatic make_sequence();
        int kind;
        int conts;
        seq_bytes.delete();
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: seq_bytes.push_back(8'($urandom_range(0, 127)));
            3, 4: begin
                seq_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                conts = 1;
            end
            5: begin
                seq_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                conts = 2;
            end
            6: begin
                seq_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                conts = 3;
            end
            7: begin
                conts = $urandom_range(1, 3);
                case (conts)
                    1: seq_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                    2: seq_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                    default: seq_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                endcase
                conts = $urandom_range(0, conts - 1);
            end
            8: seq_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
            default: seq_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
        if (kind >= 3 && kind <= 7)
            repeat (conts) seq_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    initial begin
        int  rand_sent;
        bit  paused;
        rand_sent = 0;
        paused    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_items[i]) send_byte(directed_items[i][8:1], directed_items[i][0]);
        drain();

        while (rand_sent < RAND_ITEMS) begin
            make_sequence();
            foreach (seq_bytes[i]) begin
                send_byte(seq_bytes[i], $urandom_range(0, 15) == 0);
                rand_sent++;
            end
            if (!paused && rand_sent >= RAND_ITEMS / 2) begin
                drain();
                paused = 1'b1;
            end
        end

        drain();
        repeat (8) @(posedge i_clk);

        $display("%0d bytes sent (%0d marked end of text), %0d code points checked",
                 sb.n_bytes, sb.n_ends, sb.n_results);
        $display("%0d of them replacements for broken, stray or truncated input",
                 sb.n_replaced);
        if (sb.n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
